### hdl/rrips_pkg.sv
`default_nettype none

package rrips_pkg;

    localparam int NUM_SOURCES  = 7;
    localparam int SRC_W        = $clog2(NUM_SOURCES);
    localparam int CFG_W        = 32;
    localparam int NUM_REGS     = NUM_SOURCES + 1;
    localparam int REG_IDX_W    = $clog2(NUM_REGS);
    localparam int TIME_IN_W    = 32;
    localparam int TIME_BITS_DEF = 32;

    // register map
    localparam logic [REG_IDX_W-1:0] REG_MIN_GAP       = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_INTERVAL_BASE = REG_IDX_W'(1);

    localparam logic [CFG_W-1:0] MIN_GAP_RESET = 32'd1000;
    localparam logic [CFG_W-1:0] INTERVAL_RESET [NUM_SOURCES] = '{
        32'd3000, 32'd15000, 32'd15000, 32'd5000, 32'd60000, 32'd60000, 32'd60000
    };

    typedef enum logic [1:0] {
        OUT_NONE    = 2'd0,
        OUT_ISSUED  = 2'd1,
        OUT_BLOCKED = 2'd2
    } t_outcome;

    // controller to datapath
    typedef struct packed {
        logic     capture;
        logic     step;
        logic     set_res;
        t_outcome res_code;
        logic     load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic gap_ok;
        logic src_due;
        logic out_ready;
    } t_status;

endpackage

`default_nettype wire

### hdl/rrips_ctrl.sv
`default_nettype none

module rrips_ctrl
    import rrips_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_GAP  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    localparam logic [SRC_W-1:0] LAST_CHECK = SRC_W'(NUM_SOURCES - 1);

    t_state           r_state, n_state;
    logic [SRC_W-1:0] r_cnt, n_cnt;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd.capture  = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.set_res  = 1'b0;
        o_cmd.res_code = OUT_NONE;
        o_cmd.load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_GAP;
                end
            end
            ST_GAP: begin
                n_cnt = '0;
                if (i_status.gap_ok) begin
                    n_state = ST_SCAN;
                end else begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = OUT_BLOCKED;
                    n_state        = ST_DONE;
                end
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + SRC_W'(1);
                if (i_status.src_due) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = OUT_ISSUED;
                    n_state        = ST_DONE;
                end else if (r_cnt == LAST_CHECK) begin
                    // all sources checked, pointer is back at its start
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = OUT_NONE;
                    n_state        = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

### hdl/rrips_dp.sv
`default_nettype none

module rrips_dp
    import rrips_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic [TIME_IN_W-1:0] i_time_now_ms,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic [1:0]                o_outcome,
    output logic [SRC_W-1:0]          o_source_index,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status
);

    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam logic [SRC_W-1:0] LAST_SRC = SRC_W'(NUM_SOURCES - 1);

    logic [CFG_W-1:0]     r_min_gap;
    logic [CFG_W-1:0]     r_interval [NUM_SOURCES];
    logic [TIME_BITS-1:0] r_last_poll [NUM_SOURCES];
    logic [TIME_BITS-1:0] r_last_trans;
    logic [TIME_BITS-1:0] r_now;
    logic [SRC_W-1:0]     r_ptr;
    t_outcome             r_res_code;
    logic [SRC_W-1:0]     r_res_src;
    logic                 r_out_valid;
    t_outcome             r_out_code;
    logic [SRC_W-1:0]     r_out_src;

    logic [CMP_W-1:0]     now_ext;
    logic [TIME_BITS-1:0] gap_diff;
    logic [TIME_BITS-1:0] src_diff;
    logic [SRC_W-1:0]     cfg_src;

    assign now_ext  = CMP_W'(i_time_now_ms);
    assign gap_diff = r_now - r_last_trans;
    assign src_diff = r_now - r_last_poll[r_ptr];
    assign cfg_src  = i_cfg_index - REG_INTERVAL_BASE;

    assign o_status.gap_ok    = CMP_W'(gap_diff) >= CMP_W'(r_min_gap);
    assign o_status.src_due   = CMP_W'(src_diff) >= CMP_W'(r_interval[r_ptr]);
    assign o_status.out_ready = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_out_code;
    assign o_source_index = r_out_src;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= MIN_GAP_RESET;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                r_interval[i] <= INTERVAL_RESET[i];
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_MIN_GAP) begin
                r_min_gap <= i_cfg_data;
            end else begin
                r_interval[cfg_src] <= i_cfg_data;
            end
        end
    end

    // timestamps and rotate pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                r_last_poll[i] <= '0;
            end
            r_last_trans <= '0;
            r_ptr        <= '0;
        end else if (i_cmd.step) begin
            r_ptr <= (r_ptr == LAST_SRC) ? '0 : r_ptr + SRC_W'(1);
            if (o_status.src_due) begin
                r_last_poll[r_ptr] <= r_now;
                r_last_trans       <= r_now;
            end
        end
    end

    // tick time and result, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now <= now_ext[TIME_BITS-1:0];
        end
        if (i_cmd.step && o_status.src_due) begin
            r_res_src <= r_ptr;
        end
        if (i_cmd.set_res) begin
            r_res_code <= i_cmd.res_code;
            if (i_cmd.res_code != OUT_ISSUED) begin
                r_res_src <= '0;
            end
        end
        if (i_cmd.load_out) begin
            r_out_code <= r_res_code;
            r_out_src  <= r_res_src;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### hdl/round_robin_interval_poll_scheduler.sv
// a tick is captured and checked against the minimum gap; a blocked tick skips the scan,
//   else sources are checked in turn until one is due or all seven have been checked
// the input stalls until the result is loaded; one source interval compare per cycle
// the result waits in an output register, which frees the input side
// reset (synchronous, active low): timestamps and pointer to zero, registers to defaults
`default_nettype none

module round_robin_interval_poll_scheduler
    import rrips_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [TIME_IN_W-1:0] i_time_now_ms,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_outcome,
    output logic [SRC_W-1:0]          o_source_index
);

    t_cmd    cmd;
    t_status status;

    rrips_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rrips_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_time_now_ms  (i_time_now_ms),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_outcome      (o_outcome),
        .o_source_index (o_source_index),
        .i_cmd          (cmd),
        .o_status       (status)
    );

endmodule

`default_nettype wire

### tb/sv/rrips_poll_checker.sv
`timescale 1ns / 100ps

module rrips_poll_checker
    import rrips_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [TIME_IN_W-1:0] i_time_now_ms,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [1:0]           i_outcome,
    input  wire logic [SRC_W-1:0]     i_source_index,
    output int                        o_fail_count,
    output int                        o_outstanding
);

    typedef struct packed {
        t_outcome         outcome;
        logic [SRC_W-1:0] src;
    } t_poll_result;

    // shadow of the scheduler
    logic [CFG_W-1:0]     gap_ms;
    logic [CFG_W-1:0]     interval_ms [NUM_SOURCES];
    logic [TIME_IN_W-1:0] last_poll_ms [NUM_SOURCES];
    logic [TIME_IN_W-1:0] last_xfer_ms;
    logic [SRC_W-1:0]     rr_ptr;

    t_poll_result expected_polls [$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    function automatic t_poll_result schedule_tick(input logic [TIME_IN_W-1:0] now_ms);
        t_poll_result         res;
        logic [TIME_IN_W-1:0] since;
        logic [SRC_W-1:0]     s;
        logic                 issued;
        res.outcome = OUT_NONE;
        res.src     = '0;
        since = now_ms - last_xfer_ms;
        if (since < gap_ms) begin
            res.outcome = OUT_BLOCKED;
            return res;
        end
        issued = 1'b0;
        // pointer moves past every source looked at, wraps back when none is due
        for (int k = 0; k < NUM_SOURCES && !issued; k++) begin
            s = rr_ptr;
            rr_ptr = (s == SRC_W'(NUM_SOURCES - 1)) ? '0 : s + 1'b1;
            since = now_ms - last_poll_ms[s];
            if (since >= interval_ms[s]) begin
                last_poll_ms[s] = now_ms;
                last_xfer_ms    = now_ms;
                res.outcome     = OUT_ISSUED;
                res.src         = s;
                issued          = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic void report_fail();
        o_fail_count = o_fail_count + 1;
    endfunction

    always @(posedge i_clk) begin
        t_poll_result want;
        if (!i_rst_n) begin
            gap_ms = MIN_GAP_RESET;
            for (int s = 0; s < NUM_SOURCES; s++) begin
                interval_ms[s]  = INTERVAL_RESET[s];
                last_poll_ms[s] = '0;
            end
            last_xfer_ms = '0;
            rr_ptr       = '0;
            expected_polls.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_MIN_GAP) begin
                    gap_ms = i_cfg_data;
                end else begin
                    interval_ms[i_cfg_index - REG_INTERVAL_BASE] = i_cfg_data;
                end
            end
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (expected_polls.size() == 0) begin
                    report_fail();
                    $display("%0t: result transfer, expected none, actual outcome %0d source %0d",
                             $time, i_outcome, i_source_index);
                end else begin
                    want = expected_polls.pop_front();
                    if (i_outcome !== want.outcome) begin
                        report_fail();
                        $display("%0t: outcome mismatch, expected %0d actual %0d",
                                 $time, want.outcome, i_outcome);
                    end
                    if (i_source_index !== want.src) begin
                        report_fail();
                        $display("%0t: source_index mismatch, expected %0d actual %0d",
                                 $time, want.src, i_source_index);
                    end
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                expected_polls.push_back(schedule_tick(i_time_now_ms));
            end
        end
        o_outstanding = expected_polls.size();
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb
    import rrips_pkg::*;
();

    localparam int NUM_PHASES      = 10;
    localparam int TICKS_PER_PHASE = 58;
    localparam int DRAIN_CYCLES    = 12;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic [TIME_IN_W-1:0] i_time_now_ms = '0;
    logic                 i_out_stall   = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [1:0]           o_outcome;
    logic [SRC_W-1:0]     o_source_index;

    int fail_count;
    int outstanding;

    logic [CFG_W-1:0]     gap_plan;
    logic [CFG_W-1:0]     interval_plan [NUM_SOURCES];
    logic [TIME_IN_W-1:0] cur_ms;
    int                   burst_left = 0;
    int                   stall_hold = 0;

    round_robin_interval_poll_scheduler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_time_now_ms  (i_time_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_outcome      (o_outcome),
        .o_source_index (o_source_index)
    );

    rrips_poll_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_time_now_ms  (i_time_now_ms),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_outcome      (o_outcome),
        .i_source_index (o_source_index),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: runs of free flow, runs of stall, and cycle-by-cycle noise
    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    i_out_stall <= 1'b0;
                    stall_hold  <= $urandom_range(0, 30);
                end
                2: begin
                    i_out_stall <= 1'b1;
                    stall_hold  <= $urandom_range(0, 7);
                end
                default: begin
                    i_out_stall <= 1'($urandom_range(0, 1));
                    stall_hold  <= 0;
                end
            endcase
        end else begin
            stall_hold <= stall_hold - 1;
        end
    end

    // one tick transfer; valid stays up inside a burst and drops for a random gap after it
    task automatic send_tick(input logic [TIME_IN_W-1:0] t_ms);
        int gap;
        i_in_valid    <= 1'b1;
        i_time_now_ms <= t_ms;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        cur_ms = t_ms;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
            i_in_valid    <= 1'b0;
            i_time_now_ms <= $urandom;
            repeat (gap) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic flush_and_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // write every register back to back, enable held high across the run
    task automatic load_regs();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MIN_GAP;
        i_cfg_data  <= gap_plan;
        @(posedge i_clk);
        for (int s = 0; s < NUM_SOURCES; s++) begin
            i_cfg_index <= REG_INTERVAL_BASE + REG_IDX_W'(s);
            i_cfg_data  <= interval_plan[s];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_setting(input int style, input bit for_gap);
        case (style)
            0: return for_gap ? CFG_W'($urandom_range(0, 50)) : CFG_W'($urandom_range(0, 400));
            1: return for_gap ? CFG_W'($urandom_range(500, 1500))
                              : CFG_W'($urandom_range(1000, 60000));
            2: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return $urandom;
                    default: return CFG_W'($urandom_range(0, 100));
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int style;
        int roll;
        logic [TIME_IN_W-1:0] last_ms;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: gap 1000, intervals 3000/15000/15000/5000/60000...
        send_tick(32'd0);            // blocked right after reset
        send_tick(32'd999);          // one short of the gap
        send_tick(32'd1000);         // gap met, nobody due, full scan
        send_tick(32'd3000);         // source 0 on its interval
        send_tick(32'd3999);         // blocked
        send_tick(32'd5000);         // scan reaches source 3
        send_tick(32'hFFFF_FFFF);    // top of the time range
        send_tick(32'd0);            // wrapped difference of one, blocked
        send_tick(32'd999);          // wrapped gap met, source 0 due across the wrap
        flush_and_idle();

        // zero gap and zero intervals: every tick issues, pointer walks all sources
        gap_plan = '0;
        for (int s = 0; s < NUM_SOURCES; s++) interval_plan[s] = '0;
        load_regs();
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd0);
        for (int n = 0; n < 6; n++) send_tick(cur_ms + $urandom_range(1, 1000));
        last_ms = cur_ms;
        flush_and_idle();

        // all-ones settings: only a difference of all ones passes
        gap_plan = '1;
        for (int s = 0; s < NUM_SOURCES; s++) interval_plan[s] = '1;
        load_regs();
        send_tick(last_ms);          // blocked
        send_tick(last_ms - 1);      // gap passes, last source polled found on seventh check
        send_tick(last_ms - 1);      // blocked again
        send_tick(last_ms - 2);      // same again one step down
        send_tick($urandom);
        flush_and_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            style = (p % 2 == 0) ? 0 : 1 + (p / 2) % 3;
            gap_plan = pick_setting(style, 1'b1);
            for (int s = 0; s < NUM_SOURCES; s++) interval_plan[s] = pick_setting(style, 1'b0);
            load_regs();
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 19);
                if (roll == 0) begin
                    last_ms = $urandom;
                end else if (roll == 1) begin
                    last_ms = cur_ms - $urandom_range(1, 100);
                end else begin
                    case (style)
                        0: last_ms = cur_ms + $urandom_range(0, 60);
                        1: last_ms = cur_ms + $urandom_range(0, 8000);
                        2: last_ms = cur_ms + ($urandom_range(0, 1) ? $urandom
                                                                    : $urandom_range(0, 200));
                        default: last_ms = cur_ms + $urandom;
                    endcase
                end
                send_tick(last_ms);
            end
            flush_and_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
